>>> hw/rtl/ntpc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time client package
// Shared types, codes and constants of the time client sequencer.
// ----------------------------------------------------------------------------
package ntpc_pkg;

   localparam int CSR_DATA_W = 30;
   localparam int CSR_INDEX_W = 2;
   localparam int PERIOD_MS_W = 27;
   localparam int TIMEOUT_MS_W = 20;
   localparam int SKEW_US_W = 30;
   localparam int PERIOD_US_W = 37;
   localparam int TIMEOUT_US_W = 30;
   localparam int PROD_W = 52;
   localparam int USEC_W = 20;

   localparam logic [CSR_INDEX_W-1:0] CSR_UPDATE_PERIOD = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TIMEOUT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SKEW_LIMIT = 2'd2;

   localparam logic [2:0] EV_NONE = 3'd0;
   localparam logic [2:0] EV_FIRST = 3'd1;
   localparam logic [2:0] EV_ADJUSTED = 3'd2;
   localparam logic [2:0] EV_CLAMPED = 3'd3;
   localparam logic [2:0] EV_INVALID = 3'd4;
   localparam logic [2:0] EV_TIMEOUT = 3'd5;
   localparam logic [2:0] EV_FOREIGN = 3'd6;

   localparam logic [1:0] CS_BOOTUP = 2'd0;
   localparam logic [1:0] CS_IDLE = 2'd1;
   localparam logic [1:0] CS_SENT = 2'd2;

   localparam logic [2:0] MODE_SERVER = 3'd4;
   localparam logic [15:0] REPLY_LEN = 16'd48;
   localparam logic [USEC_W-1:0] US_PER_S = 20'd1000000;
   localparam logic [9:0] US_PER_MS = 10'd1000;
   localparam logic [1:0] BOOT_REQUESTS = 2'd3;

   localparam logic [PERIOD_US_W-1:0] PERIOD_US_RESET = 37'd60000000;
   localparam logic [TIMEOUT_US_W-1:0] TIMEOUT_US_RESET = 30'd5000000;
   localparam logic [SKEW_US_W-1:0] SKEW_US_RESET = 30'd1000;

   typedef enum logic [2:0] {
      ST_BOOTUP = 3'b001,
      ST_IDLE   = 3'b010,
      ST_SENT   = 3'b100
   } proto_state_type;

   typedef struct packed {
      logic        command;
      logic [62:0] now_us;
      logic        source_match;
      logic [15:0] packet_length;
      logic [7:0]  first_byte;
      logic [7:0]  stratum_byte;
      logic [31:0] tx_seconds;
      logic [31:0] tx_fraction;
   } req_payload_type;

   typedef struct packed {
      logic        request_now;
      logic [63:0] clock_offset_us;
      logic [2:0]  event_res;
      logic [1:0]  client_state;
   } rsp_payload_type;

   typedef struct packed {
      logic [PERIOD_US_W-1:0]  period_us;
      logic [TIMEOUT_US_W-1:0] timeout_us;
      logic [SKEW_US_W-1:0]    skew_us;
   } cfg_type;

   typedef struct packed {
      logic              command;
      logic [62:0]       now_us;
      logic              source_match;
      logic              frame_ok;
      logic [PROD_W-1:0] secs_us;
      logic [USEC_W-1:0] frac_us;
   } item_type;

endpackage
`default_nettype wire

>>> hw/rtl/ntpc_req_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one poll or reply beat.
// ----------------------------------------------------------------------------
interface ntpc_req_if;
   import ntpc_pkg::*;

   logic            valid;
   logic            ready;
   req_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ntpc_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one result beat.
// ----------------------------------------------------------------------------
interface ntpc_rsp_if;
   import ntpc_pkg::*;

   logic            valid;
   logic            ready;
   rsp_payload_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/ntpc_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time client registers
// Holds the configuration, kept in microseconds so no multiply is needed later.
// ----------------------------------------------------------------------------
module ntpc_csr
   import ntpc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_UPDATE_PERIOD: begin
               cfg_in.period_us = PERIOD_US_W'(csr_write_data[PERIOD_MS_W-1:0])
                                  * PERIOD_US_W'(US_PER_MS);
            end
            CSR_TIMEOUT: begin
               cfg_in.timeout_us = TIMEOUT_US_W'(csr_write_data[TIMEOUT_MS_W-1:0])
                                   * TIMEOUT_US_W'(US_PER_MS);
            end
            CSR_SKEW_LIMIT: begin
               cfg_in.skew_us = csr_write_data[SKEW_US_W-1:0];
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_us <= PERIOD_US_RESET;
         cfg_ff.timeout_us <= TIMEOUT_US_RESET;
         cfg_ff.skew_us <= SKEW_US_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

>>> hw/rtl/ntpc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time client input stage
// Registers each request beat with its timestamp products and frame check.
// ----------------------------------------------------------------------------
module ntpc_front
   import ntpc_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   ntpc_req_if.sink   req_bus,
   input  wire logic  take,
   output logic       item_valid,
   output item_type   item
);

   logic              valid_ff;
   logic              valid_in;
   item_type          item_ff;
   item_type          item_in;
   logic [PROD_W-1:0] frac_prod;
   logic              accept;

   assign req_bus.ready = !reset && (!valid_ff || take);
   assign accept = req_bus.valid && req_bus.ready;

   always_comb begin
      frac_prod = PROD_W'(req_bus.data.tx_fraction) * PROD_W'(US_PER_S);
      item_in.command = req_bus.data.command;
      item_in.now_us = req_bus.data.now_us;
      item_in.source_match = req_bus.data.source_match;
      item_in.frame_ok = (req_bus.data.packet_length == REPLY_LEN)
                         && (req_bus.data.first_byte[2:0] == MODE_SERVER)
                         && (req_bus.data.stratum_byte != 8'd0);
      item_in.secs_us = PROD_W'(req_bus.data.tx_seconds) * PROD_W'(US_PER_S);
      item_in.frac_us = frac_prod[PROD_W-1:32];
      valid_in = accept || (valid_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (accept) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule
`default_nettype wire

>>> hw/rtl/ntpc_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time client sequencer core
// Protocol state, deadlines, offset update and the result register.
// ----------------------------------------------------------------------------
module ntpc_core
   import ntpc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire cfg_type  cfg,
   input  wire logic     item_valid,
   input  wire item_type item,
   output logic          take,
   ntpc_rsp_if.source    rsp_bus
);

   proto_state_type state_ff, state_in, state_mid;
   logic [1:0]      left_ff, left_in;
   logic [63:0]     nud_ff, nud_in;
   logic [63:0]     tdl_ff, tdl_in;
   logic            armed_ff, armed_in;
   logic [63:0]     offset_ff, offset_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic        send;
   logic [2:0]  ev;
   logic [63:0] now64, sched, tmo, instant, fresh, lim64;
   logic        expire, to_idle, boot_req, idle_req, up, down;
   logic [1:0]  cs_code;

   assign take = item_valid && (!rsp_valid_ff || rsp_bus.ready);

   always_comb begin
      now64 = {1'b0, item.now_us};
      sched = now64 + 64'(cfg.period_us);
      tmo = now64 + 64'(cfg.timeout_us);
      instant = 64'(item.secs_us) + 64'(item.frac_us);
      fresh = instant - now64;
      lim64 = 64'(cfg.skew_us);
      up = $signed(fresh) > $signed(offset_ff);
      down = $signed(fresh) < $signed(offset_ff);
      expire = armed_ff && (now64 >= tdl_ff);
      to_idle = expire && (state_ff == ST_SENT);
      state_mid = to_idle ? ST_IDLE : state_ff;
      boot_req = (state_mid == ST_BOOTUP) && (left_ff != 2'd0);
      idle_req = (state_mid == ST_IDLE)
                 && (to_idle ? (cfg.period_us == '0) : (now64 >= nud_ff));

      state_in = state_ff;
      left_in = left_ff;
      nud_in = nud_ff;
      tdl_in = tdl_ff;
      armed_in = armed_ff;
      offset_in = offset_ff;
      send = 1'b0;
      ev = EV_NONE;

      if (!item.command) begin
         state_in = state_mid;
         if (expire) begin
            armed_in = 1'b0;
         end
         if (to_idle) begin
            nud_in = sched;
            ev = EV_TIMEOUT;
         end
         if (boot_req) begin
            left_in = left_ff - 2'd1;
            tdl_in = tmo;
            armed_in = 1'b1;
            send = 1'b1;
         end
         if (idle_req) begin
            state_in = ST_SENT;
            tdl_in = tmo;
            armed_in = 1'b1;
            send = 1'b1;
         end
      end else if (!item.source_match) begin
         ev = EV_FOREIGN;
      end else begin
         if (!item.frame_ok) begin
            ev = EV_INVALID;
         end else if (state_ff == ST_BOOTUP) begin
            offset_in = fresh;
            ev = EV_FIRST;
         end else if (up && ((fresh - offset_ff) > lim64)) begin
            offset_in = offset_ff + lim64;
            ev = EV_CLAMPED;
         end else if (down && ((offset_ff - fresh) > lim64)) begin
            offset_in = offset_ff - lim64;
            ev = EV_CLAMPED;
         end else begin
            offset_in = fresh;
            ev = EV_ADJUSTED;
         end
         state_in = ST_IDLE;
         nud_in = sched;
         armed_in = 1'b0;
      end

      unique case (state_in)
         ST_BOOTUP: cs_code = CS_BOOTUP;
         ST_IDLE:   cs_code = CS_IDLE;
         ST_SENT:   cs_code = CS_SENT;
         default:   cs_code = CS_SENT;
      endcase

      rsp_data_in.request_now = send;
      rsp_data_in.clock_offset_us = offset_in;
      rsp_data_in.event_res = ev;
      rsp_data_in.client_state = cs_code;
      rsp_valid_in = take || (rsp_valid_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_BOOTUP;
         left_ff <= BOOT_REQUESTS;
         nud_ff <= '0;
         tdl_ff <= '0;
         armed_ff <= 1'b0;
         offset_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (take) begin
            state_ff <= state_in;
            left_ff <= left_in;
            nud_ff <= nud_in;
            tdl_ff <= tdl_in;
            armed_ff <= armed_in;
            offset_ff <= offset_in;
         end
      end
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;
   assign rsp_bus.data = rsp_data_ff;

   a_no_return_to_bootup: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_BOOTUP) |=> (state_ff != ST_BOOTUP))
      else $error("sequencer returned to bootup");

   a_boot_count_down_only: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> (left_ff <= $past(left_ff)))
      else $error("boot request count increased");

   a_send_only_on_poll_events: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.request_now)
         |-> (rsp_data_ff.event_res == EV_NONE || rsp_data_ff.event_res == EV_TIMEOUT))
      else $error("request raised with a reply event");

   a_clamp_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.event_res == EV_CLAMPED)
         |-> (rsp_data_ff.client_state == CS_IDLE))
      else $error("clamped reply did not return to idle");

endmodule
`default_nettype wire

>>> hw/rtl/ntp_offset_slew_client_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Time client sequencer
// A request beat passes the input register and then the result register.
// Throughput: one beat per cycle while results are taken; the state update is a single registered pass.
// A waiting result holds the next beat in the input register, and the request
// side stalls while both registers are full.
// Reset is synchronous: the client returns to bootup with three boot requests,
// cleared deadlines and offset, and the register reset values.
// ----------------------------------------------------------------------------
module ntp_offset_slew_client_top
   import ntpc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   ntpc_req_if.sink                    req_bus,
   ntpc_rsp_if.source                  rsp_bus,
   input  wire logic                   csr_write_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_write_data
);

   cfg_type  cfg;
   item_type item;
   logic     item_valid;
   logic     take;

   ntpc_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   ntpc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   ntpc_core u_core (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_valid (item_valid),
      .item       (item),
      .take       (take),
      .rsp_bus    (rsp_bus)
   );

endmodule
`default_nettype wire
